// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MVA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define MVA_ASSERT_IMPL(label, pre, post, msg) \
  `MVA_ASSERT(label, (pre) |-> (post), msg)
`else
`define MVA_ASSERT(label, prop, msg)
`define MVA_ASSERT_IMPL(label, pre, post, msg)
`endif
`endif

// ===== sv/mva_pkg.sv =====
// ----------------------------------------------------------------------------
// mva_pkg
// Types and constants of the modular vector ALU.
// ----------------------------------------------------------------------------
`default_nettype none
package mva_pkg;

  localparam int unsigned MagW = 64;
  localparam int unsigned ResW = 33;
  localparam int unsigned ScaleW = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned Lanes = 3;

  localparam logic [ResW-1:0] ModReset = 33'd65536;
  localparam logic [ScaleW-1:0] ScaleReset = 32'd1;

  localparam logic [CfgIdxW-1:0] CFG_MODULUS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCALE = 2'd1;

  // lane order in the remainder chain
  localparam int unsigned LANE_A = 0;
  localparam int unsigned LANE_B = 1;
  localparam int unsigned LANE_S = 2;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_SUB    = 3'd1,
    CMD_NEG    = 3'd2,
    CMD_SMUL   = 3'd3,
    CMD_REDUCE = 3'd4,
    CMD_SIGNED = 3'd5
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic last;
    logic neg_a;
    logic neg_s;
  } ctl_t;

endpackage
`default_nettype wire

// ===== sv/mva_rem_cell.sv =====
// ----------------------------------------------------------------------------
// mva_rem_cell
// One restoring remainder step on three lanes: shifts in the top magnitude bit.
// ----------------------------------------------------------------------------
`default_nettype none
module mva_rem_cell #(
  parameter int unsigned W = 32
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic [W:0]                              q_i,
  input  wire logic                                    valid_i,
  input  wire mva_pkg::ctl_t                           ctl_i,
  input  wire logic [mva_pkg::Lanes-1:0][mva_pkg::MagW-1:0] mag_i,
  input  wire logic [mva_pkg::Lanes-1:0][W-1:0]        rem_i,
  output logic                                         valid_o,
  output mva_pkg::ctl_t                                ctl_o,
  output logic [mva_pkg::Lanes-1:0][mva_pkg::MagW-1:0] mag_o,
  output logic [mva_pkg::Lanes-1:0][W-1:0]             rem_o
);

  logic [mva_pkg::Lanes-1:0][W:0]   t;
  logic [mva_pkg::Lanes-1:0][W-1:0] rem_d;

  always_comb begin
    for (int l = 0; l < mva_pkg::Lanes; l++) begin
      t[l] = {rem_i[l], mag_i[l][mva_pkg::MagW-1]};
      if (t[l] >= q_i) begin
        t[l] = t[l] - q_i;
      end
      rem_d[l] = t[l][W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_o <= ctl_i;
    rem_o <= rem_d;
    for (int l = 0; l < mva_pkg::Lanes; l++) begin
      mag_o[l] <= {mag_i[l][mva_pkg::MagW-2:0], 1'b0};
    end
  end

endmodule
`default_nettype wire

// ===== sv/mva_mul_cell.sv =====
// ----------------------------------------------------------------------------
// mva_mul_cell
// One double-and-add step of a modular multiply, multiplier bit taken MSB first.
// ----------------------------------------------------------------------------
`default_nettype none
module mva_mul_cell #(
  parameter int unsigned W = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [W:0]    q_i,
  input  wire logic          valid_i,
  input  wire mva_pkg::ctl_t ctl_i,
  input  wire logic [W-1:0]  x_i,
  input  wire logic [W-1:0]  y_i,
  input  wire logic [W-1:0]  acc_i,
  input  wire logic [W-1:0]  rb_i,
  output logic               valid_o,
  output mva_pkg::ctl_t      ctl_o,
  output logic [W-1:0]       x_o,
  output logic [W-1:0]       y_o,
  output logic [W-1:0]       acc_o,
  output logic [W-1:0]       rb_o
);

  logic [W:0] dbl;
  logic [W:0] sum;

  always_comb begin
    dbl = {acc_i, 1'b0};
    if (dbl >= q_i) begin
      dbl = dbl - q_i;
    end
    sum = dbl;
    if (y_i[W-1]) begin
      sum = {1'b0, dbl[W-1:0]} + {1'b0, x_i};
      if (sum >= q_i) begin
        sum = sum - q_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_o <= ctl_i;
    x_o   <= x_i;
    y_o   <= {y_i[W-2:0], 1'b0};
    acc_o <= sum[W-1:0];
    rb_o  <= rb_i;
  end

endmodule
`default_nettype wire

// ===== sv/modular_vector_alu_top.sv =====
// ----------------------------------------------------------------------------
// modular_vector_alu_top
// Elementwise modular ALU: add, subtract, negate, scalar multiply, reduce and
// signed form under a configured modulus.
// ----------------------------------------------------------------------------
// One item is taken every cycle (busy_o stays low) and its result appears on
// done_o in order, after an input stage, a row of 64 remainder cells (one
// operand bit per cell), a sign fix stage, a row of MOD_WIDTH modular multiply
// cells and the output register. Results cannot be held off: the receiver must
// take each item in the cycle done_o is high. The user must write modulus and
// scale only while no item is in flight; the block itself does not enforce it.
`default_nettype none
module modular_vector_alu_top #(
  parameter int unsigned MOD_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [2:0]                    cmd_i,
  input  wire logic signed [63:0]            operand_a_i,
  input  wire logic [31:0]                   operand_b_i,
  input  wire logic                          last_in_i,
  output logic                               done_o,
  output logic signed [mva_pkg::ResW-1:0]    result_o,
  output logic                               last_out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [mva_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [mva_pkg::ResW-1:0]      cfg_wdata_i
);

  localparam int unsigned W   = MOD_WIDTH;
  localparam int unsigned QW  = W + 1;
  localparam int unsigned CW  = (QW > mva_pkg::ResW) ? QW : mva_pkg::ResW;
  localparam int unsigned MW  = mva_pkg::MagW;
  localparam int unsigned LAT = 67 + W;

  logic [mva_pkg::ResW-1:0]   mod_q;
  logic [mva_pkg::ScaleW-1:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q   <= mva_pkg::ModReset;
      scale_q <= mva_pkg::ScaleReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mva_pkg::CFG_MODULUS: mod_q   <= cfg_wdata_i;
        mva_pkg::CFG_SCALE:   scale_q <= cfg_wdata_i[mva_pkg::ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // effective modulus, capped at 2^MOD_WIDTH
  logic [CW-1:0] mod_ext;
  logic [CW-1:0] cap;
  logic [W:0]    q;
  logic          q_zero;

  assign mod_ext = CW'(mod_q);
  assign cap     = CW'(1) << W;
  assign q       = (mod_ext > cap) ? cap[QW-1:0] : mod_ext[QW-1:0];
  assign q_zero  = (q == '0);
  assign busy_o  = 1'b0;

  // input stage
  logic                                     in_vld_q;
  mva_pkg::ctl_t                            in_ctl_q;
  logic [mva_pkg::Lanes-1:0][MW-1:0]        in_mag_q;
  logic [MW-1:0]                            scale_ext;

  assign scale_ext = MW'(signed'(scale_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    in_ctl_q.cmd   <= mva_pkg::cmd_e'(cmd_i);
    in_ctl_q.last  <= last_in_i;
    in_ctl_q.neg_a <= operand_a_i[MW-1];
    in_ctl_q.neg_s <= scale_ext[MW-1];
    in_mag_q[mva_pkg::LANE_A] <= operand_a_i[MW-1] ? (~operand_a_i + 1'b1)
                                                   : operand_a_i;
    in_mag_q[mva_pkg::LANE_B] <= MW'(operand_b_i);
    in_mag_q[mva_pkg::LANE_S] <= scale_ext[MW-1] ? (~scale_ext + 1'b1) : scale_ext;
  end

  // remainder chain
  logic                                  rc_vld [0:MW];
  mva_pkg::ctl_t                         rc_ctl [0:MW];
  logic [mva_pkg::Lanes-1:0][MW-1:0]     rc_mag [0:MW];
  logic [mva_pkg::Lanes-1:0][W-1:0]      rc_rem [0:MW];

  assign rc_vld[0] = in_vld_q;
  assign rc_ctl[0] = in_ctl_q;
  assign rc_mag[0] = in_mag_q;
  assign rc_rem[0] = '0;

  for (genvar i = 0; i < MW; i++) begin : g_rem
    mva_rem_cell #(.W(W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .q_i     (q),
      .valid_i (rc_vld[i]),
      .ctl_i   (rc_ctl[i]),
      .mag_i   (rc_mag[i]),
      .rem_i   (rc_rem[i]),
      .valid_o (rc_vld[i+1]),
      .ctl_o   (rc_ctl[i+1]),
      .mag_o   (rc_mag[i+1]),
      .rem_o   (rc_rem[i+1])
    );
  end

  // sign fix: residue of a negative value is q - m
  logic          fx_vld_q;
  mva_pkg::ctl_t fx_ctl_q;
  logic [W-1:0]  fx_ra_q;
  logic [W-1:0]  fx_rb_q;
  logic [W-1:0]  fx_rs_q;
  logic [W-1:0]  ma;
  logic [W-1:0]  ms;
  logic [W:0]    ma_neg;
  logic [W:0]    ms_neg;

  assign ma     = rc_rem[MW][mva_pkg::LANE_A];
  assign ms     = rc_rem[MW][mva_pkg::LANE_S];
  assign ma_neg = q - {1'b0, ma};
  assign ms_neg = q - {1'b0, ms};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_vld_q <= 1'b0;
    end else begin
      fx_vld_q <= rc_vld[MW];
    end
  end

  always_ff @(posedge clk_i) begin
    fx_ctl_q <= rc_ctl[MW];
    fx_rb_q  <= rc_rem[MW][mva_pkg::LANE_B];
    fx_ra_q  <= (rc_ctl[MW].neg_a && ma != '0) ? ma_neg[W-1:0] : ma;
    fx_rs_q  <= (rc_ctl[MW].neg_s && ms != '0) ? ms_neg[W-1:0] : ms;
  end

  // multiply chain
  logic          mc_vld [0:W];
  mva_pkg::ctl_t mc_ctl [0:W];
  logic [W-1:0]  mc_x   [0:W];
  logic [W-1:0]  mc_y   [0:W];
  logic [W-1:0]  mc_acc [0:W];
  logic [W-1:0]  mc_rb  [0:W];

  assign mc_vld[0] = fx_vld_q;
  assign mc_ctl[0] = fx_ctl_q;
  assign mc_x[0]   = fx_ra_q;
  assign mc_y[0]   = fx_rs_q;
  assign mc_acc[0] = '0;
  assign mc_rb[0]  = fx_rb_q;

  for (genvar k = 0; k < W; k++) begin : g_mul
    mva_mul_cell #(.W(W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .q_i     (q),
      .valid_i (mc_vld[k]),
      .ctl_i   (mc_ctl[k]),
      .x_i     (mc_x[k]),
      .y_i     (mc_y[k]),
      .acc_i   (mc_acc[k]),
      .rb_i    (mc_rb[k]),
      .valid_o (mc_vld[k+1]),
      .ctl_o   (mc_ctl[k+1]),
      .x_o     (mc_x[k+1]),
      .y_o     (mc_y[k+1]),
      .acc_o   (mc_acc[k+1]),
      .rb_o    (mc_rb[k+1])
    );
  end

  // result select
  logic [W:0]  ra;
  logic [W:0]  rb;
  logic [W:0]  sum;
  logic [W:0]  dif;
  logic [W:0]  res;
  logic [63:0] res_ext;

  assign ra = {1'b0, mc_x[W]};
  assign rb = {1'b0, mc_rb[W]};

  always_comb begin
    sum = ra + rb;
    if (sum >= q) begin
      sum = sum - q;
    end
    dif = ra - rb;
    if (ra < rb) begin
      dif = dif + q;
    end
    case (mc_ctl[W].cmd)
      mva_pkg::CMD_ADD:    res = sum;
      mva_pkg::CMD_SUB:    res = dif;
      mva_pkg::CMD_NEG:    res = (ra == '0) ? '0 : (q - ra);
      mva_pkg::CMD_SMUL:   res = {1'b0, mc_acc[W]};
      mva_pkg::CMD_REDUCE: res = ra;
      mva_pkg::CMD_SIGNED: res = (ra > (q >> 1)) ? (ra - q) : ra;
      default:             res = '0;
    endcase
    if (q_zero) begin
      res = '0;
    end
  end

  assign res_ext = {{(64 - QW){res[W]}}, res};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= mc_vld[W];
    end
  end

  always_ff @(posedge clk_i) begin
    result_o   <= res_ext[mva_pkg::ResW-1:0];
    last_out_o <= mc_ctl[W].last;
  end

`include "assert_macros.svh"

  `MVA_ASSERT_IMPL(a_fixed_latency, start_i, ##LAT done_o, "item lost in pipeline")
  `MVA_ASSERT_IMPL(a_no_spurious, !start_i, ##LAT !done_o, "result without item")
  `MVA_ASSERT_IMPL(a_last_follows, start_i && last_in_i, ##LAT last_out_o, "last flag lost")

endmodule
`default_nettype wire

// ===== tb/sv/tb_modular_vector_alu_top.sv =====
// ----------------------------------------------------------------------------
// tb_modular_vector_alu_top
// Self-checking bench for the modular vector ALU: a directed item list, then
// random items under several modulus and scale settings, checked in order
// against a predictor of the modular arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_modular_vector_alu_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ModW = 32;
  localparam int unsigned Latency = 67 + ModW;
  localparam longint unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] opa;
    logic [31:0] opb;
    logic        last;
  } elem_t;

  typedef struct packed {
    logic [mva_pkg::ResW-1:0] res;
    logic                     last;
  } resid_t;

  logic clk, rst_n;
  logic start, busy, done, last_out;
  logic [2:0] cmd;
  logic signed [63:0] opa;
  logic [31:0] opb;
  logic last_in;
  logic signed [mva_pkg::ResW-1:0] result;
  logic cfg_we;
  logic [mva_pkg::CfgIdxW-1:0] cfg_idx;
  logic [mva_pkg::ResW-1:0] cfg_wdata;

  modular_vector_alu_top #(.MOD_WIDTH(ModW)) dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .cmd_i(cmd), .operand_a_i(opa), .operand_b_i(opb), .last_in_i(last_in),
    .done_o(done), .result_o(result), .last_out_o(last_out),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  elem_t  pending_q[$];
  resid_t residue_q[$];
  logic [mva_pkg::ResW-1:0] mod_reg;
  logic [31:0]     scale_reg;
  int unsigned errors, n_checked, gap, n_items;
  longint unsigned cycles;
  bit hold;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] sres(logic [63:0] v, logic [63:0] q);
    logic [63:0] m;
    if (!v[63]) return v % q;
    m = (~v + 64'd1) % q;
    return (m != 0) ? q - m : 64'd0;
  endfunction

  function automatic resid_t modular_result(elem_t e);
    logic [63:0] q, ra, rb, rs, r;
    logic [127:0] prod;
    resid_t o;
    q = {31'd0, mod_reg};
    r = '0;
    if (q > (64'd1 << ModW)) q = 64'd1 << ModW;
    if (q != 0) begin
      ra = sres(e.opa, q);
      rb = {32'd0, e.opb} % q;
      case (e.cmd)
        mva_pkg::CMD_ADD:    r = (ra + rb >= q) ? ra + rb - q : ra + rb;
        mva_pkg::CMD_SUB:    r = (ra >= rb) ? ra - rb : ra + (q - rb);
        mva_pkg::CMD_NEG:    r = (ra != 0) ? q - ra : 64'd0;
        mva_pkg::CMD_SMUL: begin
          rs = sres({{32{scale_reg[31]}}, scale_reg}, q);
          prod = ra * rs;
          r = 64'(prod % q);
        end
        mva_pkg::CMD_REDUCE: r = ra;
        mva_pkg::CMD_SIGNED: r = (ra > (q >> 1)) ? ra - q : ra;
        default:             r = '0;
      endcase
    end
    o.res = r[mva_pkg::ResW-1:0];
    o.last = e.last;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h (item %0d)", what, got, want, n_checked);
    errors++;
  endtask

  // driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap <= 0;
    end else if (start && !busy) begin
      if (pending_q.size() != 0 && gap == 0 && !hold) begin
        elem_t e;
        e = pending_q.pop_front();
        residue_q.push_back(modular_result(e));
        {cmd, opa, opb, last_in} <= e;
        start <= 1'b1;
        n_items++;
        gap <= ($urandom_range(0, 9) < 6) ? 0 :
               ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
      end else begin
        start <= 1'b0;
      end
    end else if (gap != 0) begin
      gap <= gap - 1;
    end else if (pending_q.size() != 0 && !hold) begin
      elem_t e;
      e = pending_q.pop_front();
      residue_q.push_back(modular_result(e));
      {cmd, opa, opb, last_in} <= e;
      start <= 1'b1;
      n_items++;
      gap <= ($urandom_range(0, 9) < 6) ? 0 :
             ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    if (rst_n && done) begin
      if (residue_q.size() == 0) begin
        report_mismatch("unexpected result", {31'd0, result}, 64'd0);
      end else begin
        resid_t w;
        w = residue_q.pop_front();
        if (result !== w.res) report_mismatch("result", {31'd0, result}, {31'd0, w.res});
        if (last_out !== w.last) report_mismatch("last", last_out, w.last);
        n_checked++;
      end
    end
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(logic [mva_pkg::CfgIdxW-1:0] idx, logic [mva_pkg::ResW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == mva_pkg::CFG_MODULUS) mod_reg = val;
    else scale_reg = val[31:0];
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || residue_q.size() != 0 || start) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_opa(logic [63:0] q);
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return -longint'($urandom_range(0, 1000));
      2: return (q != 0) ? {$urandom, $urandom} % q : 64'd0;
      3: return q - 64'd1 + $urandom_range(0, 2);
      default: return {32'd0, $urandom} % ((q != 0) ? q : 64'd1);
    endcase
  endfunction

  task automatic add_random(int unsigned n);
    elem_t e;
    logic [63:0] q;
    q = {31'd0, mod_reg};
    repeat (n) begin
      e.cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(0, 5));
      e.opa = rand_opa(q);
      e.opb = ($urandom_range(0, 3) == 0) ? $urandom
                                          : 32'({32'd0, $urandom} % ((q != 0) ? q : 64'd1));
      e.last = $urandom_range(0, 7) == 0;
      pending_q.push_back(e);
    end
  endtask

  initial begin
    elem_t e;
    logic [mva_pkg::ResW-1:0] mods[8];
    logic [31:0] scales[8];
    errors = 0; n_checked = 0; n_items = 0; cycles = 0; hold = 1'b0;
    mod_reg = mva_pkg::ModReset; scale_reg = mva_pkg::ScaleReset;
    start = 1'b0; cmd = '0; opa = '0; opb = '0; last_in = 1'b0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_wdata = '0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, every command, operand extremes
    for (int c = 0; c < 8; c++) begin
      e.cmd = 3'(c); e.opa = 64'h8000_0000_0000_0000; e.opb = 32'hFFFF_FFFF;
      e.last = c[0];
      pending_q.push_back(e);
      e.opa = 64'h7FFF_FFFF_FFFF_FFFF; e.opb = 32'd0; e.last = ~c[0];
      pending_q.push_back(e);
    end
    e.cmd = mva_pkg::CMD_SIGNED; e.opa = 64'd32768; e.opb = '0; e.last = 0;
    pending_q.push_back(e);
    e.opa = 64'd32769; pending_q.push_back(e);
    e.cmd = mva_pkg::CMD_NEG; e.opa = 64'd0; pending_q.push_back(e);
    e.cmd = mva_pkg::CMD_SUB; e.opa = 64'd3; e.opb = 32'd65535; pending_q.push_back(e);
    e.cmd = mva_pkg::CMD_SMUL; e.opa = -64'sd1; pending_q.push_back(e);
    drain();

    mods = '{33'd0, 33'd1, 33'd2, 33'h1_0000_0000, 33'h1_FFFF_FFFF, 33'd65521,
             33'hFFFF_FFFB, 33'd12289};
    scales = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000,
               32'd3, 32'h7FFF_FFFF, 32'hDEAD_BEEF};
    for (int p = 0; p < 8; p++) begin
      write_reg(mva_pkg::CFG_MODULUS, mods[p]);
      write_reg(mva_pkg::CFG_SCALE, {1'b0, scales[p]});
      add_random(30);
      if (p == 7) begin
        while (pending_q.size() != 0) @(posedge clk);
        hold = 1'b1;
        while (residue_q.size() != 0) @(posedge clk);
        hold = 1'b0;
      end
      drain();
      write_reg(mva_pkg::CFG_MODULUS, 33'($urandom_range(2, 32'hFFFF_FFFF)));
      write_reg(mva_pkg::CFG_SCALE, {1'b0, $urandom});
      add_random(30);
      drain();
    end

    $display("covered %0d items over 16 modulus/scale settings, %0d results checked",
             n_items, n_checked);
    $display("settings included zero, one, two, 2^32 and saturating moduli");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
